[hdl/stick_hysteresis_autorepeat_defines.svh]
// Assertion helpers for the stick direction block.
`ifndef STICK_HYSTERESIS_AUTOREPEAT_DEFINES_SVH
`define STICK_HYSTERESIS_AUTOREPEAT_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain property under reset.
`define SHA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition now implies consequence at the next edge.
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define SHA_ASSERT(label, clk, rst_n, prop)
`define SHA_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

[hdl/sha_pkg.sv]
package sha_pkg;

    localparam int USERS      = 4;
    localparam int AXES       = 4;
    localparam int USERS_SEEN = (USERS < 4) ? USERS : 4;
    localparam int ENTRIES    = USERS_SEEN * AXES;
    localparam int IDX_W      = $clog2(ENTRIES);

    localparam int USER_W = 2;
    localparam int AXIS_W = 2;
    localparam int SCAN_W = USER_W + AXIS_W;
    localparam int VAL_W  = 16;
    localparam int THR_W  = 15;
    localparam int CNT_W  = 16;
    localparam int KIND_W = 2;
    localparam int DIR_W  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INT  = 3'd3;

    localparam logic [THR_W-1:0] PRESS_THR_RST   = 15'd16384;
    localparam logic [THR_W-1:0] RELEASE_THR_RST = 15'd13107;
    localparam logic [CNT_W-1:0] INIT_DELAY_RST  = 16'd200;
    localparam logic [CNT_W-1:0] REPEAT_INT_RST  = 16'd100;

    // held direction codes
    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_NEG  = 2'd2;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPEAT  = 2'd2;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic [DIR_W-1:0] dir;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } ram_req_t;

endpackage

[hdl/sha_channels.sv]
interface sha_in_if;
    import sha_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [USER_W-1:0]        user;
    logic [AXIS_W-1:0]        axis;
    logic signed [VAL_W-1:0]  value;

    modport source (output valid, output func, output user, output axis, output value,
                    input ready);
    modport sink   (input valid, input func, input user, input axis, input value,
                    output ready);
endinterface

interface sha_out_if;
    import sha_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  event_kind;
    logic [USER_W-1:0]  user_out;
    logic [AXIS_W-1:0]  axis_out;
    logic               negative_dir;
    logic               last;

    modport source (output valid, output event_kind, output user_out, output axis_out,
                    output negative_dir, output last, input ready);
    modport sink   (input valid, input event_kind, input user_out, input axis_out,
                    input negative_dir, input last, output ready);
endinterface

interface sha_cfg_if;
    import sha_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/sha_state_ram.sv]
module sha_state_ram (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::ram_req_t req,
    output sha_pkg::entry_t   rd_entry
);
    import sha_pkg::*;

    entry_t               mem [ENTRIES];
    logic [ENTRIES-1:0]   vld_reg;
    entry_t               rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // per-entry written flags; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;

endmodule

[hdl/stick_hysteresis_autorepeat.sv]
// Stick direction events: each analog axis sample of a user is compared with the press and
// release thresholds (Q1.15 magnitudes, with hysteresis) and yields nothing, a press, a
// release, or a release followed by a press of the opposite direction. A tick word walks
// all user/axis entries in ascending order and emits a repeat for every held direction whose
// countdown expires; the last word of each item has last set. Per-entry state (held
// direction and repeat countdown) lives in one RAM with a registered read and a separate
// write port; a tick walks one entry per cycle, fetching the next entry while the current
// one is written back, except while a pending repeat waits on a stalled event sink. Input
// is taken only when the previous item is finished; one event word can sit in the output
// register while the next item is being worked on. Configuration writes are always ready
// and should only be issued while the block is idle.
`include "stick_hysteresis_autorepeat_defines.svh"

module stick_hysteresis_autorepeat (
    input  logic       clk,
    input  logic       rst_n,
    sha_in_if.sink     stick,
    sha_out_if.source  events,
    sha_cfg_if.sink    cfg
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMP,
        S_EV,
        T_SCAN,
        T_END
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [USER_W-1:0] user;
        logic [AXIS_W-1:0] axis;
        logic              neg;
    } evt_t;

    state_t             state_reg;

    // configuration
    logic [THR_W-1:0]   press_thr_reg;
    logic [THR_W-1:0]   release_thr_reg;
    logic [CNT_W-1:0]   init_delay_reg;
    logic [CNT_W-1:0]   repeat_int_reg;

    // output register and one-deep lookahead, so last can be set on the final word
    logic               out_valid_reg;
    evt_t               out_evt_reg;
    logic               out_last_reg;
    logic               pend_valid_reg;
    evt_t               pend_evt_reg;

    // item context
    logic [SCAN_W-1:0]  scan_reg;
    logic [USER_W-1:0]  smp_user_reg;
    logic [AXIS_W-1:0]  smp_axis_reg;
    logic [VAL_W-1:0]   smp_val_reg;
    logic               ev_rel_reg;
    logic               ev_press_reg;
    logic               rel_neg_reg;
    logic               press_neg_reg;

    ram_req_t           ram_req;
    entry_t             rd_entry;

    logic               in_accept;
    logic               out_free;
    logic               push_ok;
    logic [SCAN_W-1:0]  smp_idx;
    logic [SCAN_W-1:0]  smp_reg_idx;
    logic [SCAN_W-1:0]  scan_inc;
    logic               scan_last;

    // sample evaluation
    logic signed [VAL_W:0] v_s;
    logic signed [VAL_W:0] p_s;
    logic signed [VAL_W:0] r_s;
    logic [DIR_W-1:0]      cur_dir;
    logic [DIR_W-1:0]      new_dir;
    logic                  dir_change;

    // tick evaluation
    logic               held;
    logic               expire;
    logic               scan_step;
    evt_t               rep_evt;

    sha_state_ram u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (ram_req),
        .rd_entry (rd_entry)
    );

    assign stick.ready = (state_reg == S_IDLE);
    assign in_accept   = stick.valid && stick.ready;
    assign cfg.ready   = 1'b1;

    assign out_free = !out_valid_reg || events.ready;
    // a push moves the pending word out, so it needs room there
    assign push_ok  = !pend_valid_reg || out_free;

    assign smp_idx     = {stick.user, stick.axis};
    assign smp_reg_idx = {smp_user_reg, smp_axis_reg};
    assign scan_inc    = scan_reg + 1'b1;
    assign scan_last   = (scan_reg == SCAN_W'(ENTRIES - 1));

    // hysteresis: press beats hold, hold needs release magnitude on its own side
    always_comb
    begin
        v_s     = {smp_val_reg[VAL_W-1], smp_val_reg};
        p_s     = {2'b00, press_thr_reg};
        r_s     = {2'b00, release_thr_reg};
        cur_dir = rd_entry.dir;
        new_dir = DIR_NONE;
        if (v_s >= p_s)
        begin
            new_dir = DIR_POS;
        end
        else if (v_s <= -p_s)
        begin
            new_dir = DIR_NEG;
        end
        else if ((cur_dir == DIR_POS && v_s >= r_s) || (cur_dir == DIR_NEG && v_s <= -r_s))
        begin
            new_dir = cur_dir;
        end
        dir_change = (new_dir != cur_dir);
    end

    // a countdown of 0 or 1 expires, so zero delays act as one tick
    assign held      = (rd_entry.dir != DIR_NONE);
    assign expire    = held && (rd_entry.cnt <= CNT_W'(1));
    assign scan_step = !expire || push_ok;
    assign rep_evt   = '{kind: KIND_REPEAT,
                         user: scan_reg[SCAN_W-1:AXIS_W],
                         axis: scan_reg[AXIS_W-1:0],
                         neg:  (rd_entry.dir == DIR_NEG)};

    always_comb
    begin
        ram_req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_req.rd_en   = in_accept;
                ram_req.rd_addr = (stick.func == FUNC_TICK) ? '0 : smp_idx[IDX_W-1:0];
            end
            S_SAMP:
            begin
                ram_req.wr_en       = dir_change;
                ram_req.wr_addr     = smp_reg_idx[IDX_W-1:0];
                ram_req.wr_data.dir = new_dir;
                ram_req.wr_data.cnt = (new_dir != DIR_NONE) ? init_delay_reg : rd_entry.cnt;
            end
            T_SCAN:
            begin
                // next entry is fetched while this one is written back
                ram_req.rd_en       = scan_step && !scan_last;
                ram_req.rd_addr     = scan_inc[IDX_W-1:0];
                ram_req.wr_en       = scan_step && held;
                ram_req.wr_addr     = scan_reg[IDX_W-1:0];
                ram_req.wr_data.dir = rd_entry.dir;
                ram_req.wr_data.cnt = expire ? repeat_int_reg : rd_entry.cnt - 1'b1;
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_thr_reg   <= PRESS_THR_RST;
            release_thr_reg <= RELEASE_THR_RST;
            init_delay_reg  <= INIT_DELAY_RST;
            repeat_int_reg  <= REPEAT_INT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_PRESS_THR:   press_thr_reg   <= cfg.data[THR_W-1:0];
                CFG_RELEASE_THR: release_thr_reg <= cfg.data[THR_W-1:0];
                CFG_INIT_DELAY:  init_delay_reg  <= cfg.data;
                CFG_REPEAT_INT:  repeat_int_reg  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            smp_user_reg <= stick.user;
            smp_axis_reg <= stick.axis;
            smp_val_reg  <= stick.value;
        end
        if (state_reg == S_SAMP)
        begin
            rel_neg_reg   <= (cur_dir == DIR_NEG);
            press_neg_reg <= (new_dir == DIR_NEG);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            scan_reg       <= '0;
            ev_rel_reg     <= 1'b0;
            ev_press_reg   <= 1'b0;
        end
        else
        begin
            if (events.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (stick.func == FUNC_TICK)
                        begin
                            scan_reg  <= '0;
                            state_reg <= T_SCAN;
                        end
                        else if (int'(stick.user) < USERS_SEEN)
                        begin
                            state_reg <= S_SAMP;
                        end
                    end
                end

                S_SAMP:
                begin
                    ev_rel_reg   <= dir_change && (cur_dir != DIR_NONE);
                    ev_press_reg <= dir_change && (new_dir != DIR_NONE);
                    state_reg    <= S_EV;
                end

                S_EV:
                begin
                    if (push_ok)
                    begin
                        if (ev_rel_reg || ev_press_reg)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_evt_reg   <= pend_evt_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_valid_reg    <= 1'b1;
                            pend_evt_reg.user <= smp_user_reg;
                            pend_evt_reg.axis <= smp_axis_reg;
                            // release always goes first
                            if (ev_rel_reg)
                            begin
                                pend_evt_reg.kind <= KIND_RELEASE;
                                pend_evt_reg.neg  <= rel_neg_reg;
                                ev_rel_reg        <= 1'b0;
                            end
                            else
                            begin
                                pend_evt_reg.kind <= KIND_PRESS;
                                pend_evt_reg.neg  <= press_neg_reg;
                                ev_press_reg      <= 1'b0;
                            end
                        end
                        else
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_evt_reg   <= pend_evt_reg;
                                out_last_reg  <= 1'b1;
                            end
                            pend_valid_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end

                T_SCAN:
                begin
                    if (scan_step)
                    begin
                        if (expire)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_evt_reg   <= pend_evt_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_evt_reg   <= rep_evt;
                        end
                        if (scan_last)
                        begin
                            state_reg <= T_END;
                        end
                        else
                        begin
                            scan_reg <= scan_inc;
                        end
                    end
                end

                T_END:
                begin
                    // flush the final repeat with last set
                    if (push_ok)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_evt_reg   <= pend_evt_reg;
                            out_last_reg  <= 1'b1;
                        end
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign events.valid        = out_valid_reg;
    assign events.event_kind   = out_evt_reg.kind;
    assign events.user_out     = out_evt_reg.user;
    assign events.axis_out     = out_evt_reg.axis;
    assign events.negative_dir = out_evt_reg.neg;
    assign events.last         = out_last_reg;

    // nothing may be left in the lookahead once an item is done
    `SHA_ASSERT(a_idle_no_pend, clk, rst_n, (state_reg == S_IDLE) |-> !pend_valid_reg)
    // state RAM is written only by the sample update and the tick scan
    `SHA_ASSERT(a_wr_state, clk, rst_n, ram_req.wr_en |-> (state_reg == S_SAMP || state_reg == T_SCAN))
    // the scan ends right after the last entry
    `SHA_ASSERT_NEXT(a_scan_end, clk, rst_n, (state_reg == T_SCAN && scan_last && scan_step), (state_reg == T_END))

endmodule
